// File: src/vrt_pkg.sv
// Shared constants and codes for the voxel ray traversal core.
// No dependencies; imported by vrt_div, voxel_ray_traversal_core, vrt_checker and testbench.
package vrt_pkg;

  localparam int ITER_LIMIT = 1000;
  localparam int ITER_W     = 17;
  localparam int DIV_W      = 31;   // dividend width: up to 1.0 in Q.16 shifted by 14
  localparam int DVS_W      = 16;   // divisor width: direction magnitude
  localparam int CNT_W      = 5;

  localparam logic [1:0] KIND_QUERY = 2'd0;
  localparam logic [1:0] KIND_HIT   = 2'd1;
  localparam logic [1:0] KIND_MISS  = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_STEP  = 2'd2;

  localparam logic [DIV_W-1:0] ONE_SH14 = DIV_W'(32'd1 << 30);

endpackage

// File: src/vrt_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on vrt_pkg for widths.
module vrt_div import vrt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0] dvd_r;
  logic [DIV_W-1:0] q_r;
  logic [DVS_W:0]   rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh = {rem_r[DVS_W-1:0], dvd_r[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        rem_r <= ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
        q_r   <= {q_r[DIV_W-2:0], ge};
        dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: src/voxel_ray_traversal_core.sv
// Voxel grid walker: sequencer around a shared serial divider and multiplier.
// Depends on vrt_pkg and vrt_div.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/ready   | action, origin, dir, voxel flags
//   out     | output    | out_valid/ready  | result_kind, cell_x/y/z
//   cfg     | input     | cfg_we           | cfg_wdata (max_reach)
//
// A start beat runs one 31-step division per non-zero direction axis through
// the shared divider.
// A reply beat that advances runs axis select, three multiply/accumulate
// pairs, then one division for the crossed axis.
// Hits, misses and steps with no moving axis go straight to the emit state,
// and an ignored reply stays idle. Reset is synchronous.
// A finished result sits in the output register; in_ready drops while
// a ray start or step is in flight or a result waits for the output register.
module voxel_ray_traversal_core import vrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic               in_voxel_present,
  input  logic               in_voxel_solid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic signed [15:0] out_cell_x,
  output logic signed [15:0] out_cell_y,
  output logic signed [15:0] out_cell_z,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SDIV  = 3'd1;
  localparam logic [2:0] S_SWAIT = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ACC   = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_FWAIT = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]              st_r;
  logic [1:0]              phase_r;
  logic [1:0]              ax_r;
  logic [1:0]              sel_r;
  logic [23:0]             max_reach_r;
  logic [31:0]             pos_r  [3];
  logic [15:0]             cell_r [3];
  logic signed [15:0]      dir_r  [3];
  logic [31:0]             face_r [3];
  logic [31:0]             reach_r;
  logic [31:0]             t_r;
  logic [ITER_W-1:0]       iter_r;
  logic signed [48:0]      prod_r;
  logic [1:0]              kind_r;
  logic                    out_valid_r;
  logic [1:0]              out_kind_r;
  logic [15:0]             out_cell_r [3];

  logic                    div_start;
  logic [DIV_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  logic                    div_done;
  logic [DIV_W-1:0]        div_q;

  logic                    accept;
  logic signed [15:0]      dir_ax;
  logic [15:0]             mag_ax;
  logic [16:0]             num_ax;
  logic [1:0]              best;
  logic                    found;
  logic [31:0]             reach_dec;

  assign accept = in_valid && in_ready;
  assign dir_ax = dir_r[ax_r];
  assign mag_ax = dir_ax[15] ? 16'(-dir_ax) : 16'(dir_ax);
  assign num_ax = dir_ax[15] ? {1'b0, pos_r[ax_r][15:0]}
                             : 17'h10000 - {1'b0, pos_r[ax_r][15:0]};
  assign reach_dec = reach_r - t_r;

  // least face distance among moving axes, ties to the lower axis
  always_comb begin
    best  = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (dir_r[i] != 16'sd0) begin
        if (!found || face_r[i] < face_r[best]) begin
          best = 2'(i);
        end
        found = 1'b1;
      end
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = ONE_SH14;
    div_dvs   = mag_ax;
    if (st_r == S_SDIV && dir_ax != 16'sd0) begin
      div_start = 1'b1;
      div_dvd   = {num_ax, 14'd0};
    end else if (st_r == S_FIX) begin
      div_start = 1'b1;
    end
  end

  vrt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= PH_IDLE;
      ax_r        <= 2'd0;
      max_reach_r <= 24'd393216;
      out_valid_r <= 1'b0;
      iter_r      <= '0;
      reach_r     <= '0;
    end else begin
      if (cfg_we) begin
        max_reach_r <= cfg_wdata;
      end
      // the emit state reloads the output register itself
      if (out_valid_r && out_ready && st_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (accept) begin
            if (!in_action) begin
              pos_r[0]  <= in_origin_x;
              pos_r[1]  <= in_origin_y;
              pos_r[2]  <= in_origin_z;
              cell_r[0] <= in_origin_x[31:16];
              cell_r[1] <= in_origin_y[31:16];
              cell_r[2] <= in_origin_z[31:16];
              dir_r[0]  <= in_dir_x;
              dir_r[1]  <= in_dir_y;
              dir_r[2]  <= in_dir_z;
              ax_r      <= 2'd0;
              st_r      <= S_SDIV;
            end else if (phase_r != PH_IDLE) begin
              if (!in_voxel_present) begin
                kind_r <= KIND_MISS;
                st_r   <= S_EMIT;
              end else if (phase_r == PH_STEP && iter_r == '0) begin
                kind_r <= KIND_MISS;
                st_r   <= S_EMIT;
              end else begin
                if (phase_r == PH_STEP) begin
                  iter_r <= iter_r - 1'b1;
                end
                if ($signed(reach_r) <= 32'sd0) begin
                  kind_r <= KIND_MISS;
                  st_r   <= S_EMIT;
                end else if (in_voxel_solid) begin
                  kind_r <= KIND_HIT;
                  st_r   <= S_EMIT;
                end else if (!found) begin
                  phase_r <= PH_STEP;
                  kind_r  <= KIND_QUERY;
                  st_r    <= S_EMIT;
                end else begin
                  sel_r <= best;
                  t_r   <= face_r[best];
                  ax_r  <= 2'd0;
                  st_r  <= S_MUL;
                end
              end
            end
          end
        end
        S_SDIV: begin
          if (dir_ax == 16'sd0) begin
            face_r[ax_r] <= '0;
            if (ax_r == 2'd2) begin
              reach_r <= {8'd0, max_reach_r};
              iter_r  <= ITER_W'(ITER_LIMIT + 1);
              phase_r <= PH_FIRST;
              kind_r  <= KIND_QUERY;
              st_r    <= S_EMIT;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end else begin
            st_r <= S_SWAIT;
          end
        end
        S_SWAIT: begin
          if (div_done) begin
            face_r[ax_r] <= {1'b0, div_q};
            if (ax_r == 2'd2) begin
              reach_r <= {8'd0, max_reach_r};
              iter_r  <= ITER_W'(ITER_LIMIT + 1);
              phase_r <= PH_FIRST;
              kind_r  <= KIND_QUERY;
              st_r    <= S_EMIT;
            end else begin
              ax_r <= ax_r + 1'b1;
              st_r <= S_SDIV;
            end
          end
        end
        S_MUL: begin
          prod_r <= $signed(49'(dir_ax)) * $signed(49'({1'b0, t_r}));
          st_r   <= S_ACC;
        end
        S_ACC: begin
          // arithmetic shift by 14 is the floor of the move
          pos_r[ax_r] <= pos_r[ax_r] + 32'(prod_r[45:14]);
          if (dir_ax != 16'sd0) begin
            face_r[ax_r] <= face_r[ax_r] - t_r;
          end
          if (ax_r == 2'd2) begin
            ax_r <= sel_r;
            st_r <= S_FIX;
          end else begin
            ax_r <= ax_r + 1'b1;
            st_r <= S_MUL;
          end
        end
        S_FIX: begin
          // snap the crossed axis onto its face
          if (!dir_ax[15]) begin
            cell_r[ax_r] <= cell_r[ax_r] + 1'b1;
            pos_r[ax_r]  <= {cell_r[ax_r] + 16'd1, 16'd0};
          end else begin
            cell_r[ax_r] <= cell_r[ax_r] - 1'b1;
            pos_r[ax_r]  <= {cell_r[ax_r], 16'd0};
          end
          reach_r <= reach_dec;
          st_r    <= S_FWAIT;
        end
        S_FWAIT: begin
          if (div_done) begin
            face_r[ax_r] <= {1'b0, div_q};
            if (reach_r[31]) begin
              kind_r <= KIND_MISS;
            end else begin
              phase_r <= PH_STEP;
              kind_r  <= KIND_QUERY;
            end
            st_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= kind_r;
            for (int i = 0; i < 3; i++) begin
              out_cell_r[i] <= (kind_r == KIND_MISS) ? 16'd0 : cell_r[i];
            end
            if (kind_r != KIND_QUERY) begin
              phase_r <= PH_IDLE;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (st_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_cell_x      = out_cell_r[0];
  assign out_cell_y      = out_cell_r[1];
  assign out_cell_z      = out_cell_r[2];

`ifndef SYNTH
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == KIND_MISS |->
      out_cell_r[0] == 16'd0 && out_cell_r[1] == 16'd0 && out_cell_r[2] == 16'd0)
    else $error("miss carries a cell");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == S_SWAIT || st_r == S_FWAIT)
    else $error("divider finished outside a wait");
  a_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
    iter_r <= ITER_W'(ITER_LIMIT + 1))
    else $error("iteration count out of range");
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EMIT && (!out_valid_r || out_ready) |=> st_r == S_IDLE && out_valid_r)
    else $error("result not loaded");
`endif

endmodule

// File: test/vrt_checker.sv
// Scoreboard for voxel_ray_traversal_core: watches the input, output and config ports,
// runs a grid-walk predictor and compares every output beat with it.
// Depends on vrt_pkg.
`timescale 1ns / 1ps
module vrt_checker import vrt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_action,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [15:0] in_dir_x,
  input  logic signed [15:0] in_dir_y,
  input  logic signed [15:0] in_dir_z,
  input  logic               in_voxel_present,
  input  logic               in_voxel_solid,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_result_kind,
  input  logic signed [15:0] out_cell_x,
  input  logic signed [15:0] out_cell_y,
  input  logic signed [15:0] out_cell_z,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending,
  output int                 hits_seen,
  output int                 beats_seen
);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } walk_result_t;

  walk_result_t   walk_q[$];
  logic [23:0]    reach_cfg;
  logic [31:0]    pos[3];
  logic [15:0]    walk_cell[3];
  int             sgn[3];
  logic [31:0]    fdist[3];
  logic signed [31:0] reach_left;
  int unsigned    iters_left;
  logic [1:0]     walk_phase;
  int             dirv[3];

  function automatic longint unsigned dir_mag(int d);
    return d < 0 ? longint'(-d) : longint'(d);
  endfunction

  function automatic longint floor14(longint v);
    if (v >= 0) return v >>> 14;
    return -((-v + 16383) >>> 14);
  endfunction

  function automatic walk_result_t make_result(logic [1:0] kind, bit with_cell);
    walk_result_t r;
    r.kind = kind;
    r.cx = with_cell ? walk_cell[0] : '0;
    r.cy = with_cell ? walk_cell[1] : '0;
    r.cz = with_cell ? walk_cell[2] : '0;
    if (kind != KIND_QUERY) walk_phase = PH_IDLE;
    return r;
  endfunction

  function automatic walk_result_t step_ray();
    int a;
    logic [31:0] t;
    longint mv;
    a = -1;
    for (int i = 0; i < 3; i++)
      if (sgn[i] != 0 && (a < 0 || fdist[i] < fdist[a])) a = i;
    if (a >= 0) begin
      t = fdist[a];
      for (int i = 0; i < 3; i++) begin
        mv = floor14(longint'(dirv[i]) * longint'({32'd0, t}));
        pos[i] = pos[i] + 32'(mv);
        if (sgn[i] != 0) fdist[i] = fdist[i] - t;
      end
      if (sgn[a] > 0) begin
        walk_cell[a] = walk_cell[a] + 16'd1;
        pos[a] = {walk_cell[a], 16'd0};
      end else begin
        pos[a] = {walk_cell[a], 16'd0};
        walk_cell[a] = walk_cell[a] - 16'd1;
      end
      fdist[a] = 32'((64'd65536 << 14) / dir_mag(dirv[a]));
      reach_left = 32'(longint'(reach_left) - longint'({32'd0, t}));
      if (reach_left < 0) return make_result(KIND_MISS, 1'b0);
    end
    walk_phase = PH_STEP;
    return make_result(KIND_QUERY, 1'b1);
  endfunction

  // returns 1 when the beat yields a result
  function automatic bit predict_walk(output walk_result_t r);
    logic [31:0] o[3];
    logic [15:0] dv[3];
    logic [31:0] num;
    o = '{in_origin_x, in_origin_y, in_origin_z};
    dv = '{in_dir_x, in_dir_y, in_dir_z};
    if (!in_action) begin
      for (int i = 0; i < 3; i++) begin
        dirv[i] = $signed(dv[i]);
        pos[i] = o[i];
        walk_cell[i] = o[i][31:16];
        if (dirv[i] == 0) begin
          sgn[i] = 0;
          fdist[i] = '0;
        end else begin
          num = dirv[i] > 0 ? 32'd65536 - o[i][15:0] : {16'd0, o[i][15:0]};
          sgn[i] = dirv[i] > 0 ? 1 : -1;
          fdist[i] = 32'(({32'd0, num} << 14) / dir_mag(dirv[i]));
        end
      end
      reach_left = {8'd0, reach_cfg};
      iters_left = ITER_LIMIT + 1;
      walk_phase = PH_FIRST;
      r = make_result(KIND_QUERY, 1'b1);
      return 1;
    end
    if (walk_phase == PH_IDLE) return 0;
    if (!in_voxel_present) begin
      r = make_result(KIND_MISS, 1'b0);
      return 1;
    end
    if (walk_phase == PH_STEP) begin
      if (iters_left == 0) begin
        r = make_result(KIND_MISS, 1'b0);
        return 1;
      end
      iters_left--;
    end
    if (reach_left <= 0) r = make_result(KIND_MISS, 1'b0);
    else if (in_voxel_solid) r = make_result(KIND_HIT, 1'b1);
    else r = step_ray();
    return 1;
  endfunction

  always @(posedge clk) begin
    walk_result_t r, exp_r;
    if (!rst_n) begin
      reach_cfg <= 24'd393216;
      walk_phase = PH_IDLE;
      for (int i = 0; i < 3; i++) begin
        pos[i] = '0; walk_cell[i] = '0; sgn[i] = 0; fdist[i] = '0; dirv[i] = 0;
      end
      reach_left = '0;
      iters_left = 0;
      walk_q.delete();
      fail_count <= 0;
      hits_seen <= 0;
      beats_seen <= 0;
    end else begin
      if (cfg_we) reach_cfg <= cfg_wdata;
      if (out_valid && out_ready) begin
        r = '{out_result_kind, out_cell_x, out_cell_y, out_cell_z};
        beats_seen <= beats_seen + 1;
        if (r.kind == KIND_HIT) hits_seen <= hits_seen + 1;
        if (walk_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, r);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = walk_q.pop_front();
          if (r !== exp_r) begin
            $display("%0t: mismatch expected kind %0d cell %0d,%0d,%0d",
                     $time, exp_r.kind, exp_r.cx, exp_r.cy, exp_r.cz,
                     " actual kind %0d cell %0d,%0d,%0d",
                     r.kind, r.cx, r.cy, r.cz);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready && predict_walk(r)) walk_q.push_back(r);
    end
    pending = walk_q.size();
  end

endmodule

// File: test/testbench.sv
// Stimulus and verdict for voxel_ray_traversal_core: directed rays, then random
// walks with reply sequences, bursty sending and output stalls. Uses vrt_checker.
`timescale 1ns / 1ps
module testbench import vrt_pkg::*;;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = 1'b0;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [15:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic in_voxel_present = 1'b0, in_voxel_solid = 1'b0;
  logic out_valid, out_ready = 1'b0;
  logic [1:0] out_result_kind;
  logic signed [15:0] out_cell_x, out_cell_y, out_cell_z;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;
  int fail_count, pending, hits_seen, beats_seen;
  int idle_cycles;
  int burst_left;
  bit stall_mode = 1'b0;

  always #6 clk = ~clk;

  voxel_ray_traversal_core u_dut (.*);

  vrt_checker u_check (.*);

  // receiver stall pattern: alternating phases of no stalls and heavy stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(bit act, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                           bit present, bit solid);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_action <= act;
    in_origin_x <= ox; in_origin_y <= oy; in_origin_z <= oz;
    in_dir_x <= dx; in_dir_y <= dy; in_dir_z <= dz;
    in_voxel_present <= present; in_voxel_solid <= solid;
    do @(posedge clk); while (!(in_ready === 1'b1));
    @(negedge clk);
    if (burst_left == 0) in_valid <= 1'b0;
  endtask

  task automatic start_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
    send_beat(1'b0, ox, oy, oz, dx, dy, dz, 1'($urandom), 1'($urandom));
  endtask

  task automatic reply(bit present, bit solid);
    send_beat(1'b1, $urandom, $urandom, $urandom,
              16'($urandom), 16'($urandom), 16'($urandom), present, solid);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reach(logic [23:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_dir();
    case ($urandom_range(0, 7))
      0: return 16'sd0;
      1: return 16'sd16384;
      2: return -16'sd16384;
      3: return 16'(-32768);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [31:0] rand_origin();
    case ($urandom_range(0, 5))
      0: return {16'($urandom), 16'd0};
      1: return $urandom & 32'h000F_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reply with no ray in flight is dropped
    reply(1'b1, 1'b0);
    // walk with default reach until reach runs out
    start_ray(32'h0000_8000, 32'h0001_4000, 32'hFFFF_C000, 16'sd9000, -16'sd7000, 16'sd11000);
    repeat (12) reply(1'b1, 1'b0);
    // solid hit on the first cell, then unloaded miss
    start_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'sd16384, 16'sd0, 16'sd0);
    reply(1'b1, 1'b1);
    start_ray(32'h0, 32'h0, 32'h0, -16'sd16384, 16'sd0, 16'sd0);
    reply(1'b1, 1'b0);
    reply(1'b0, 1'b1);
    // start while busy abandons the ray; face crossing with negative dirs
    start_ray(32'hFFFF_0000, 32'h0003_0000, 32'h0, 16'(-32768), -16'sd100, 16'sd1);
    start_ray(32'h0002_0000, 32'h0, 32'h0001_0000, -16'sd5000, -16'sd5000, -16'sd5000);
    repeat (4) reply(1'b1, 1'b0);

    write_reach(24'd0);
    start_ray(32'h0, 32'h0, 32'h0, 16'sd16384, 16'sd16384, 16'sd16384);
    reply(1'b1, 1'b1);
    // maximum reach: zero direction walks into the iteration limit
    write_reach(24'hFF_FFFF);
    start_ray(32'h1234_5678, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0);
    for (int i = 0; i < ITER_LIMIT + 3; i++) reply(1'b1, 1'b0);
    // long walk at tiny step on a diagonal
    start_ray(32'h0, 32'h0, 32'h0, 16'sd1, 16'sd1, 16'sd1);
    repeat (20) reply(1'b1, 1'b0);

    n = 0;
    while (n < 500) begin
      if (n % 120 == 0) begin
        case ($urandom_range(0, 3))
          0: write_reach(24'd393216);
          1: write_reach(24'($urandom_range(0, 24'hFF_FFFF)));
          2: write_reach(24'($urandom_range(0, 24'h02_0000)));
          default: write_reach(24'h10_0000);
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: random beat of either kind
        send_beat(1'($urandom), $urandom, $urandom, $urandom,
                  16'($urandom), 16'($urandom), 16'($urandom),
                  1'($urandom), 1'($urandom));
        n++;
      end else begin
        start_ray(rand_origin(), rand_origin(), rand_origin(), rand_dir(), rand_dir(),
                  rand_dir());
        n++;
        repeat ($urandom_range(0, 10)) begin
          reply($urandom_range(0, 15) != 0, $urandom_range(0, 5) == 0);
          n++;
        end
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
